@@ hdl/ftrf_pkg.sv @@
// Package for the fan tach RPM filter: command struct, field widths and the
// duty-to-cutoff table. No dependencies.
package ftrf_pkg;

	localparam int EDGE_WINDOW_DEF   = 10;
	localparam int AVERAGE_DEPTH_DEF = 20;

	localparam int SPEED_W  = 10;
	localparam int DUTY_W   = 7;
	localparam int RPM_W    = 12;
	localparam int PROD_W   = 16;  // tach_speed * 60 fits in 16 bits
	localparam int SHIFT_N  = PROD_W + 1;

	localparam int RPM_PER_RPS = 60;
	localparam int CUT_SCALE   = 62500;   // 2500^2 / 100
	localparam int CUT_OFFSET  = 218750;  // 2500^2 * 0.035
	localparam int CUT_MIN_DUTY = 4;

	localparam int DUTY_CODES = 1 << DUTY_W;

	typedef logic [RPM_W-1:0] cutoff_table_t [DUTY_CODES];

	// Controller to datapath commands, one step each.
	typedef struct packed {
		logic load;    // request accepted, capture fields and edge flag
		logic calc;    // product, cutoff, old sample read
		logic shift;   // halving, ring write, running total
		logic finish;  // mean into output register
	} ftrf_cmd_t;

	// floor(sqrt(62500*d - 218750)) for every duty code, 0 below 4 percent.
	function automatic cutoff_table_t build_cutoff_table();
		cutoff_table_t t;
		int unsigned   v;
		int unsigned   root;
		int unsigned   bit_v;
		for (int d = 0; d < DUTY_CODES; d++) begin
			if (d < CUT_MIN_DUTY) begin
				t[d] = '0;
			end else begin
				v     = CUT_SCALE * d - CUT_OFFSET;
				root  = 0;
				bit_v = 32'd1 << 30;
				for (int i = 0; i < 16; i++) begin
					if (v >= root + bit_v) begin
						v    = v - (root + bit_v);
						root = (root >> 1) + bit_v;
					end else begin
						root = root >> 1;
					end
					bit_v = bit_v >> 2;
				end
				t[d] = RPM_W'(root);
			end
		end
		return t;
	endfunction

	localparam cutoff_table_t CUTOFF_TABLE = build_cutoff_table();

endpackage

@@ hdl/ftrf_ctrl.sv @@
// Sequencer for the fan tach RPM filter: handshakes and step commands.
// Depends on ftrf_pkg.
module ftrf_ctrl import ftrf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      tick_valid,
	output logic      tick_stall,
	output logic      rpm_valid,
	input  logic      rpm_stall,
	output ftrf_cmd_t cmd
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_CALC  = 2'd1;
	localparam logic [1:0] ST_SHIFT = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0] state_q;
	logic       rpm_valid_q;
	logic       out_busy;

	assign out_busy   = rpm_valid_q && rpm_stall;
	assign tick_stall = (state_q != ST_IDLE);
	assign rpm_valid  = rpm_valid_q;

	assign cmd.load   = tick_valid && (state_q == ST_IDLE);
	assign cmd.calc   = (state_q == ST_CALC);
	assign cmd.shift  = (state_q == ST_SHIFT);
	assign cmd.finish = (state_q == ST_DONE) && !out_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rpm_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.load) state_q <= ST_CALC;
				end
				ST_CALC:  state_q <= ST_SHIFT;
				ST_SHIFT: state_q <= ST_DONE;
				ST_DONE: begin
					if (cmd.finish) state_q <= ST_IDLE;
				end
				default:  state_q <= ST_IDLE;
			endcase

			if (cmd.finish) begin
				rpm_valid_q <= 1'b1;
			end else if (!rpm_stall) begin
				rpm_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ hdl/ftrf_datapath.sv @@
// Datapath of the fan tach RPM filter: edge ring, cutoff lookup, halving,
// sample ring memory, running total and mean. Depends on ftrf_pkg.
module ftrf_datapath import ftrf_pkg::*; #(
	parameter int EDGE_WINDOW   = EDGE_WINDOW_DEF,
	parameter int AVERAGE_DEPTH = AVERAGE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ftrf_cmd_t          cmd,
	input  logic               fall_seen,
	input  logic [SPEED_W-1:0] tach_speed,
	input  logic [DUTY_W-1:0]  duty_percent,
	output logic [RPM_W-1:0]   rpm
);

	localparam int EPTR_W  = (EDGE_WINDOW > 1) ? $clog2(EDGE_WINDOW) : 1;
	localparam int SPTR_W  = (AVERAGE_DEPTH > 1) ? $clog2(AVERAGE_DEPTH) : 1;
	localparam int TOTAL_W = RPM_W + $clog2(AVERAGE_DEPTH);
	// Exact mean by reciprocal: total < 2^TOTAL_W, error stays below 1/depth.
	localparam int RECIP_SH = TOTAL_W + $clog2(AVERAGE_DEPTH);
	localparam longint unsigned RECIP_L =
		((64'd1 << RECIP_SH) + AVERAGE_DEPTH - 1) / AVERAGE_DEPTH;
	localparam logic [RECIP_SH-1:0] RECIP = RECIP_SH'(RECIP_L);
	localparam int MULT_W = TOTAL_W + RECIP_SH;

	// edge ring and captured fields
	logic [EDGE_WINDOW-1:0] edge_hist_q;
	logic [EPTR_W-1:0]      eptr_q;
	logic [SPEED_W-1:0]     speed_q;
	logic [DUTY_W-1:0]      duty_q;

	// calc step
	logic                   spin_s1;
	logic [PROD_W-1:0]      prod_s1;
	logic [RPM_W-1:0]       cutoff_s1;
	logic [RPM_W-1:0]       mem_rd_s1;
	logic                   old_vld_s1;

	// sample ring
	logic [RPM_W-1:0]         sample_mem [AVERAGE_DEPTH];
	logic [AVERAGE_DEPTH-1:0] sample_vld_q;
	logic [SPTR_W-1:0]        sptr_q;
	logic [TOTAL_W-1:0]       total_q;
	logic [RPM_W-1:0]         rpm_q;

	logic [RPM_W-1:0]   sample;
	logic [RPM_W-1:0]   old_sample;
	logic [MULT_W-1:0]  mean_prod;

	// smallest shift that brings the product to or under the cutoff
	always_comb begin
		sample = '0;
		if (spin_s1) begin
			for (int k = SHIFT_N - 1; k >= 0; k--) begin
				if ((prod_s1 >> k) <= PROD_W'(cutoff_s1)) sample = RPM_W'(prod_s1 >> k);
			end
		end
	end

	assign old_sample = old_vld_s1 ? mem_rd_s1 : '0;
	assign mean_prod  = MULT_W'(total_q) * MULT_W'(RECIP);
	assign rpm        = rpm_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_hist_q  <= '0;
			eptr_q       <= '0;
			sample_vld_q <= '0;
			sptr_q       <= '0;
			total_q      <= '0;
		end else begin
			if (cmd.load) begin
				edge_hist_q[eptr_q] <= fall_seen;
				eptr_q <= (eptr_q == EPTR_W'(EDGE_WINDOW - 1)) ? '0 : eptr_q + 1'b1;
			end
			if (cmd.shift) begin
				sample_vld_q[sptr_q] <= 1'b1;
				total_q <= total_q - TOTAL_W'(old_sample) + TOTAL_W'(sample);
				sptr_q  <= (sptr_q == SPTR_W'(AVERAGE_DEPTH - 1)) ? '0 : sptr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			speed_q <= tach_speed;
			duty_q  <= duty_percent;
		end
		if (cmd.calc) begin
			spin_s1    <= |edge_hist_q;
			prod_s1    <= PROD_W'(speed_q) * PROD_W'(RPM_PER_RPS);
			cutoff_s1  <= CUTOFF_TABLE[duty_q];
			old_vld_s1 <= sample_vld_q[sptr_q];
		end
		if (cmd.finish) begin
			rpm_q <= mean_prod[RECIP_SH +: RPM_W];
		end
	end

	// sample memory: registered read in calc, write in shift
	always_ff @(posedge clk) begin
		if (cmd.calc) mem_rd_s1 <= sample_mem[sptr_q];
		if (cmd.shift) sample_mem[sptr_q] <= sample;
	end

endmodule

@@ hdl/fan_tach_rpm_filter_unit.sv @@
// Fan tach RPM filter, top level; depends on ftrf_pkg, ftrf_ctrl and ftrf_datapath.
// An accepted request runs calc, shift and finish steps; rpm_valid rises at finish.
// No new request is taken until the load/calc/shift/finish sequence has run to its end;
// a result still stalled at the next finish step holds that step and the input.
// A new request is taken while the previous result waits in the output register.
// Reset (arst_n low) clears edge ring, sample valid bits, pointers, total and rpm_valid.
module fan_tach_rpm_filter_unit import ftrf_pkg::*; #(
	parameter int EDGE_WINDOW   = EDGE_WINDOW_DEF,
	parameter int AVERAGE_DEPTH = AVERAGE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               tick_valid,
	output logic               tick_stall,
	input  logic               fall_seen,
	input  logic [SPEED_W-1:0] tach_speed,
	input  logic [DUTY_W-1:0]  duty_percent,
	output logic               rpm_valid,
	input  logic               rpm_stall,
	output logic [RPM_W-1:0]   rpm
);

	ftrf_cmd_t cmd;

	ftrf_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick_valid (tick_valid),
		.tick_stall (tick_stall),
		.rpm_valid  (rpm_valid),
		.rpm_stall  (rpm_stall),
		.cmd        (cmd)
	);

	ftrf_datapath #(
		.EDGE_WINDOW   (EDGE_WINDOW),
		.AVERAGE_DEPTH (AVERAGE_DEPTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.fall_seen    (fall_seen),
		.tach_speed   (tach_speed),
		.duty_percent (duty_percent),
		.rpm          (rpm)
	);

endmodule

@@ tb/tb_fan_tach_rpm_filter_unit.sv @@
// Testbench for fan_tach_rpm_filter_unit: directed and random measurement ticks,
// predicted rpm checked in order by a small scoreboard with its own edge and sample rings.
// Depends on ftrf_pkg and the fan_tach_rpm_filter_unit RTL.
`timescale 1ns / 100ps

class rpm_scoreboard;
	bit                   edge_ring[ftrf_pkg::EDGE_WINDOW_DEF];
	bit [ftrf_pkg::RPM_W-1:0] sample_ring[ftrf_pkg::AVERAGE_DEPTH_DEF];
	int unsigned          edge_idx;
	int unsigned          sample_idx;
	int unsigned          ring_sum;
	bit [ftrf_pkg::RPM_W-1:0] rpm_q[$];
	int unsigned          ticks;
	int unsigned          spin_ticks;
	int unsigned          checked;
	int unsigned          errors;

	// floor(2500*sqrt(duty/100 - 0.035)) by integer bisection
	function int unsigned duty_ceiling(int unsigned duty);
		int unsigned v;
		int unsigned lo;
		int unsigned hi;
		int unsigned mid;
		if (duty < ftrf_pkg::CUT_MIN_DUTY)
			return 0;
		v  = ftrf_pkg::CUT_SCALE * duty - ftrf_pkg::CUT_OFFSET;
		lo = 0;
		hi = 4096;
		while (hi - lo > 1) begin
			mid = (lo + hi) / 2;
			if (mid * mid <= v)
				lo = mid;
			else
				hi = mid;
		end
		return lo;
	endfunction

	function void note_tick(bit fall, bit [ftrf_pkg::SPEED_W-1:0] speed,
			bit [ftrf_pkg::DUTY_W-1:0] duty);
		bit          spinning;
		int unsigned smp;
		int unsigned cut;
		edge_ring[edge_idx] = fall;
		edge_idx = (edge_idx == ftrf_pkg::EDGE_WINDOW_DEF - 1) ? 0 : edge_idx + 1;
		spinning = 1'b0;
		foreach (edge_ring[i])
			spinning |= edge_ring[i];
		smp = 0;
		if (spinning) begin
			cut = duty_ceiling(duty);
			smp = speed * ftrf_pkg::RPM_PER_RPS;
			while (smp > cut)
				smp = smp >> 1;
			spin_ticks++;
		end
		ring_sum = ring_sum - sample_ring[sample_idx] + smp;
		sample_ring[sample_idx] = ftrf_pkg::RPM_W'(smp);
		sample_idx = (sample_idx == ftrf_pkg::AVERAGE_DEPTH_DEF - 1) ? 0 : sample_idx + 1;
		rpm_q.push_back(ftrf_pkg::RPM_W'(ring_sum / ftrf_pkg::AVERAGE_DEPTH_DEF));
		ticks++;
	endfunction

	function void check_rpm(logic [ftrf_pkg::RPM_W-1:0] got);
		bit [ftrf_pkg::RPM_W-1:0] want;
		if (rpm_q.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("%0t: rpm %0d arrived with nothing expected", $time, got);
			return;
		end
		want = rpm_q.pop_front();
		checked++;
		if (got !== want) begin
			errors++;
			if (errors <= 10)
				$display("%0t: rpm mismatch, expected %0d, got %0d", $time, want, got);
		end
	endfunction
endclass

module tb_fan_tach_rpm_filter_unit import ftrf_pkg::*; ();

	localparam int STUCK_LIMIT = 2000;
	localparam int HOLD_CYCLES = 80;
	localparam int RANDOM_TICKS = 526;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               tick_valid = 1'b0;
	logic               tick_stall;
	logic               fall_seen = 1'b0;
	logic [SPEED_W-1:0] tach_speed = '0;
	logic [DUTY_W-1:0]  duty_percent = '0;
	logic               rpm_valid;
	logic               rpm_stall = 1'b0;
	logic [RPM_W-1:0]   rpm;

	rpm_scoreboard sb = new;
	bit            quiet = 1'b0;
	bit            hold_request = 1'b0;
	int unsigned   stuck_cycles = 0;

	fan_tach_rpm_filter_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.tick_valid   (tick_valid),
		.tick_stall   (tick_stall),
		.fall_seen    (fall_seen),
		.tach_speed   (tach_speed),
		.duty_percent (duty_percent),
		.rpm_valid    (rpm_valid),
		.rpm_stall    (rpm_stall),
		.rpm          (rpm)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (tick_valid && !tick_stall)
				sb.note_tick(fall_seen, tach_speed, duty_percent);
			if (rpm_valid && !rpm_stall)
				sb.check_rpm(rpm);
			if ((tick_valid && !tick_stall) || (rpm_valid && !rpm_stall))
				stuck_cycles <= 0;
			else
				stuck_cycles <= stuck_cycles + 1;
		end
	end

	// result side: random stalls, plus one long hold-off to back the block up
	initial begin
		forever begin
			@(posedge clk);
			if (hold_request) begin
				rpm_stall <= 1'b1;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
				hold_request = 1'b0;
			end else begin
				rpm_stall <= !quiet && ($urandom_range(99) < 11);
			end
		end
	end

	initial begin
		while (stuck_cycles < STUCK_LIMIT)
			@(posedge clk);
		$display("Timeout: no request or result moved for %0d cycles", STUCK_LIMIT);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Called just after the clock rises; leaves tick_valid high on return.
	task automatic send_tick(input bit f, input bit [SPEED_W-1:0] s,
			input bit [DUTY_W-1:0] d);
		int unsigned gap;
		gap = (!quiet && $urandom_range(99) < 11) ? $urandom_range(1, 6) : 0;
		if (gap != 0) begin
			tick_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		tick_valid   <= 1'b1;
		fall_seen    <= f;
		tach_speed   <= s;
		duty_percent <= d;
		do
			@(posedge clk);
		while (!(tick_valid && !tick_stall));
	endtask

	task automatic send_random_ticks(input int unsigned count);
		int unsigned          dead_left;
		bit                   f;
		bit [SPEED_W-1:0]     s;
		bit [DUTY_W-1:0]      d;
		dead_left = 0;
		for (int unsigned i = 0; i < count; i++) begin
			quiet = (i >= 300 && i < 400);
			if (i == 150)
				hold_request = 1'b1;
			// runs of missing edges let the fan spin down
			if (dead_left != 0) begin
				f = 1'b0;
				dead_left--;
			end else if ($urandom_range(99) < 6) begin
				f = 1'b0;
				dead_left = $urandom_range(4, 14);
			end else begin
				f = ($urandom_range(99) < 75);
			end
			case ($urandom_range(3))
				0: s = SPEED_W'($urandom_range(0, 1023));
				1: s = SPEED_W'($urandom_range(0, 45));
				2: s = SPEED_W'($urandom_range(15, 90));
				default: s = ($urandom_range(1)) ? 10'h3FF : SPEED_W'($urandom_range(0, 1023));
			endcase
			case ($urandom_range(9))
				0: d = DUTY_W'($urandom_range(0, 5));
				1: d = DUTY_W'($urandom_range(101, 127));
				default: d = DUTY_W'($urandom_range(0, 100));
			endcase
			send_tick(f, s, d);
		end
		quiet = 1'b0;
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// no edge seen yet: fan stopped, sample 0
		send_tick(1'b0, 10'd1023, 7'd100);
		send_tick(1'b1, 10'd1023, 7'd100);
		send_tick(1'b1, 10'd1023, 7'd127);
		send_tick(1'b1, 10'd1023, 7'd0);
		send_tick(1'b1, 10'd500, 7'd3);
		send_tick(1'b1, 10'd3, 7'd4);
		send_tick(1'b1, 10'd2, 7'd4);
		send_tick(1'b1, 10'd0, 7'd100);
		send_tick(1'b1, 10'd40, 7'd100);
		send_tick(1'b1, 10'd41, 7'd100);
		send_tick(1'b1, 10'd1, 7'd127);
		send_tick(1'b1, 10'd46, 7'd127);
		send_tick(1'b1, 10'd700, 7'd101);
		send_tick(1'b1, 10'd341, 7'd85);
		// ten ticks with no edge: the last one drops out of the spinning state
		for (int i = 0; i < 10; i++)
			send_tick(1'b0, 10'd512, 7'd64);

		send_random_ticks(RANDOM_TICKS);
		tick_valid <= 1'b0;

		while (sb.rpm_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("Sent %0d ticks, %0d of them with the fan spinning; %0d rpm results checked",
			sb.ticks, sb.spin_ticks, sb.checked);
		$display("Covered duty 0..127, full speed range, spin-down and a long result hold-off");
		if (sb.errors == 0 && sb.rpm_q.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("%0d errors, %0d results still expected", sb.errors, sb.rpm_q.size());
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/ftrf_pkg.sv
hdl/ftrf_ctrl.sv
hdl/ftrf_datapath.sv
hdl/fan_tach_rpm_filter_unit.sv
tb/tb_fan_tach_rpm_filter_unit.sv
